FILE: sv/plat_pkg.sv
// plat_pkg: request, result, token and write types for the peer latency aging table
// shared by the cell, the top level and the checker; no dependencies
`default_nettype none

package plat_pkg;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  CFG_ENABLE   = 1'b0;
    localparam logic [0:0]  CFG_INTERVAL = 1'b1;
    localparam int          CFG_DATA_W   = 10;

    localparam int          FRAME_W      = 31;
    localparam int          LEAD_W       = 8;
    localparam int          LEVEL_W      = 8;
    localparam int          WORST_LEAD_W = 7;
    // expiry span is interval times four
    localparam int          EXPIRY_SHIFT = 2;
    localparam int          SPAN_W       = CFG_DATA_W + EXPIRY_SHIFT;
    localparam int          CMP_W        = FRAME_W + 2;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 10'd16;

    typedef struct packed {
        logic [2:0]                peer_index;
        logic signed [LEAD_W-1:0]  peer_lead;
        logic [LEVEL_W-1:0]        peer_level;
        logic [FRAME_W-1:0]        report_frame;
        logic [FRAME_W-1:0]        current_frame;
    } t_req;

    typedef struct packed {
        logic [WORST_LEAD_W-1:0]   worst_lead;
        logic [LEVEL_W-1:0]        worst_level;
    } t_rsp;

    // running maximum handed from cell to cell
    typedef struct packed {
        logic                      vld;
        logic [WORST_LEAD_W-1:0]   lead;
        logic [LEVEL_W-1:0]        level;
    } t_tok;

    // entry write broadcast to one cell
    typedef struct packed {
        logic                      en;
        logic signed [LEAD_W-1:0]  lead;
        logic [LEVEL_W-1:0]        level;
        logic [FRAME_W-1:0]        frame;
    } t_wr;

endpackage

`default_nettype wire

FILE: sv/plat_cell.sv
// plat_cell: one peer entry of the aging table plus one stage of the max sweep
// depends on plat_pkg
`default_nettype none

module plat_cell
    import plat_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_wr                i_wr,
    input  wire logic [FRAME_W-1:0] i_now,
    input  wire logic [SPAN_W-1:0]  i_span,
    input  wire t_tok               i_tok,
    output      t_tok               o_tok
);

    logic signed [LEAD_W-1:0] r_lead;
    logic [LEVEL_W-1:0]       r_level;
    logic [FRAME_W-1:0]       r_last;
    t_tok                     r_tok;

    logic [CMP_W-1:0]         w_limit;
    logic                     w_expired;
    logic                     w_lead_gt;
    logic                     w_level_gt;

    // 33-bit compare, cannot wrap
    assign w_limit    = {2'b00, r_last} + {{(CMP_W-SPAN_W){1'b0}}, i_span};
    assign w_expired  = {2'b00, i_now} >= w_limit;
    assign w_lead_gt  = r_lead > $signed({1'b0, i_tok.lead});
    assign w_level_gt = r_level > i_tok.level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_level <= '0;
            r_last  <= '0;
            r_tok   <= '0;
        end else begin
            if (i_wr.en) begin
                r_lead  <= i_wr.lead;
                r_level <= i_wr.level;
                r_last  <= i_wr.frame;
            end else if (i_tok.vld && w_expired) begin
                r_lead  <= '0;
                r_level <= '0;
            end
            r_tok.vld   <= i_tok.vld;
            r_tok.lead  <= (!w_expired && w_lead_gt) ? r_lead[WORST_LEAD_W-1:0] : i_tok.lead;
            r_tok.level <= (!w_expired && w_level_gt) ? r_level : i_tok.level;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: sv/peer_latency_aging_table.sv
// peer_latency_aging_table: top level, control, output staging and the cell chain
// depends on plat_pkg and plat_cell
`default_nettype none

// Per-peer latency table with aging. A request names a peer, its lead, its
// level, the frame of its report and the current frame. With the enable
// register clear, or a lead of zero, the request is taken and dropped with
// no result. Otherwise the entry of that peer is written at the accepting
// edge (a peer index at or beyond PEERS writes nothing) and a sweep token
// enters a chain of PEERS cells, one cell per cycle. Each cell clears its
// entry if the current frame is at or past last frame + 4 * report_interval
// and otherwise folds its lead and level into the running maximum. The
// result (largest positive lead, largest level, zero if none) leaves the
// last cell and is staged in the output register, or in a one-deep
// pending register while that is still held by a stall. A working
// request holds input stall high until its token leaves the last cell,
// so the next request cannot be taken before then; a pending result
// keeps the input stalled until it moves into the output register. A
// dropped request does not stall the input. Configuration writes are
// meant for idle periods only.

module peer_latency_aging_table
    import plat_pkg::*;
#(
    parameter int PEERS = 8
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // request channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_req                  i_in_data,
    // result channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_rsp                  o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                r_state;
    t_state                n_state;

    // configuration registers
    logic                  r_enable;
    logic [CFG_DATA_W-1:0] r_interval;

    // sweep context held for the whole walk
    logic [FRAME_W-1:0]    r_now;
    logic                  r_start;

    // output staging
    logic                  r_out_vld;
    t_rsp                  r_out;
    logic                  r_pend_vld;
    t_rsp                  r_pend;

    logic                  w_accept;
    logic                  w_take;
    logic                  w_can_load;
    logic [SPAN_W-1:0]     w_span;
    t_tok                  w_tok [PEERS+1];
    t_wr                   w_wr  [PEERS];
    t_tok                  w_tail;

    assign o_in_stall = (r_state != S_IDLE) || r_pend_vld;
    assign w_accept   = i_in_valid && !o_in_stall;
    // a request does work only when enabled and its lead is nonzero
    assign w_take     = w_accept && r_enable && (i_in_data.peer_lead != '0);
    assign w_span     = {r_interval, {EXPIRY_SHIFT{1'b0}}};
    assign w_tail     = w_tok[PEERS];
    assign w_can_load = !r_out_vld || !i_out_stall;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                CFG_INTERVAL: r_interval <= i_cfg_wdata;
                default:      r_enable   <= r_enable;
            endcase
        end
    end

    // walk control: idle until a working request, back once the token leaves the chain
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_take) n_state = S_WALK;
            S_WALK:  if (w_tail.vld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_now <= i_in_data.current_frame;
        end
    end

    // token enters cell zero with an empty maximum
    assign w_tok[0] = '{vld: r_start, lead: '0, level: '0};

    for (genvar g = 0; g < PEERS; g++) begin : g_cell
        // the entry write lands at the accepting edge, before the sweep starts
        assign w_wr[g] = '{en:    w_take && (int'(i_in_data.peer_index) == g),
                           lead:  i_in_data.peer_lead,
                           level: i_in_data.peer_level,
                           frame: i_in_data.report_frame};

        plat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[g]),
            .i_now   (r_now),
            .i_span  (w_span),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // output register with a one-deep pending stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            // output free: refill from pending first, else from the chain
            if (w_can_load) begin
                r_out_vld <= r_pend_vld || w_tail.vld;
            end
            if (w_can_load) begin
                r_pend_vld <= 1'b0;
            end else if (w_tail.vld) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_load && r_pend_vld) begin
            r_out <= r_pend;
        end else if (w_can_load && w_tail.vld) begin
            r_out <= '{worst_lead: w_tail.lead, worst_level: w_tail.level};
        end
        if (!w_can_load && w_tail.vld) begin
            r_pend <= '{worst_lead: w_tail.lead, worst_level: w_tail.level};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: sv/plat_checker.sv
// plat_checker: port-level assertions for peer_latency_aging_table, bound to the top level
// depends on plat_pkg
`default_nettype none

module plat_checker
    import plat_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  o_in_stall,
    input  wire t_req                  i_in_data,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_rsp                  o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left block busy");

    // a zero-lead request is dropped without starting a walk
    a_zero_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.peer_lead == '0) |=> !o_in_stall)
        else $error("zero-lead request started a walk");

    // a result only appears after a walk held the input off
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a walk");

    // a result only leaves when taken
    a_out_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("result dropped without being taken");

endmodule

bind peer_latency_aging_table plat_checker u_plat_checker (.*);

`default_nettype wire
